### rtl/core/fwb_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes, types and helpers of the failure window blocklist
// depends on nothing; used by the channel interfaces, the blocklist and the testbench

package fwb_pkg;

   localparam int NUM_DISKS   = 64;
   localparam int MAX_RECORDS = 16;
   localparam int NUM_KINDS   = 2;

   localparam int DISK_W      = 6;
   localparam int KIND_W      = 2;
   localparam int TIME_W      = 32;
   localparam int THR_W       = 5;
   localparam int OUTCOME_W   = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   localparam int RING_DEPTH  = NUM_DISKS * NUM_KINDS;
   localparam int RING_W      = $clog2(RING_DEPTH);
   localparam int SLOT_W      = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
   localparam int TIMES_DEPTH = RING_DEPTH * MAX_RECORDS;
   localparam int TIMES_AW    = $clog2(TIMES_DEPTH);
   localparam int CAUSE_AW    = (NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1;

   // command codes
   localparam logic CMD_REPORT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // error kinds
   localparam logic [KIND_W-1:0] KIND_CONNECT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_IO      = 2'd1;

   // outcome codes
   localparam logic [OUTCOME_W-1:0] OUTCOME_UNKNOWN   = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_ALREADY   = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_NO_POLICY = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUTCOME_RECORDED  = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUTCOME_NEW_BLOCK = 3'd4;
   localparam logic [OUTCOME_W-1:0] OUTCOME_QUERY     = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CONNECT_WINDOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONNECT_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONNECT_POLICY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_WINDOW       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_THRESHOLD    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_POLICY       = 3'd5;

   typedef struct packed {
      logic [SLOT_W-1:0] head;
      logic [CNT_W-1:0]  count;
   } ring_meta_type;

   // head plus offset, both below MAX_RECORDS, folded back into the ring
   function automatic logic [SLOT_W-1:0] wrap_slot(input logic [CNT_W:0] sum);
      logic [CNT_W:0] folded;
      folded = sum;
      if (sum >= (CNT_W + 1)'(MAX_RECORDS)) begin
         folded = sum - (CNT_W + 1)'(MAX_RECORDS);
      end
      return folded[SLOT_W-1:0];
   endfunction

   function automatic logic [TIMES_AW-1:0] times_addr(input logic [RING_W-1:0] ring,
                                                      input logic [SLOT_W-1:0] slot);
      return TIMES_AW'(ring) * TIMES_AW'(MAX_RECORDS) + TIMES_AW'(slot);
   endfunction

endpackage

### rtl/core/fwb_channels.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces: request, response and register write
// depends on fwb_pkg for field widths

interface fwb_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [fwb_pkg::DISK_W-1:0]    disk_index;
   logic [fwb_pkg::KIND_W-1:0]    error_kind;
   logic [fwb_pkg::TIME_W-1:0]    now_ms;

   modport source (output valid, cmd, disk_index, error_kind, now_ms, input ready);
   modport sink   (input valid, cmd, disk_index, error_kind, now_ms, output ready);
endinterface

interface fwb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fwb_pkg::OUTCOME_W-1:0] outcome;
   logic                          blocked;
   logic                          block_reason;
   logic [fwb_pkg::CNT_W-1:0]     window_failures;

   modport source (output valid, outcome, blocked, block_reason, window_failures,
                   input ready);
   modport sink   (input valid, outcome, blocked, block_reason, window_failures,
                   output ready);
endinterface

interface fwb_csr_if;
   logic                           valid;
   logic                           ready;
   logic [fwb_pkg::CSR_IDX_W-1:0]  index;
   logic [fwb_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/fwb_ram.sv
`timescale 1ns / 1ps
// generic simple dual port ram: one write port, one read port, registered read
// depends on nothing

module fwb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/failure_window_blocklist.sv
`timescale 1ns / 1ps
// Failure reports and status queries for virtual disks, one at a time. A query or a report that
// is rejected (unknown kind, disk already blocked, policy off) is settled in the lookup state and
// passes through the result registers to the output register; a report with a zero window blocks
// at once on the same path. Any other report walks the disk's stored timestamps of that kind
// through the single read port of the timestamp memory, one per cycle, n of them, n being the
// stored count after the new time is added (at most 16), then closes and writes its result. The
// next transfer is taken in the cycle the result appears, unless the output register still holds
// an earlier result that the receiver has not taken. Ring bookkeeping is cleared by per-entry
// valid bits, so no clearing pass runs after reset. Depends on fwb_pkg, fwb_channels and fwb_ram.

module failure_window_blocklist (
   input logic        clock,
   input logic        reset,
   fwb_req_if.sink    req_chan,
   fwb_rsp_if.source  rsp_chan,
   fwb_csr_if.sink    csr_chan
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOOKUP = 3'd1;
   localparam logic [2:0] ST_PRUNE  = 3'd2;
   localparam logic [2:0] ST_CLOSE  = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   // configuration
   logic [fwb_pkg::TIME_W-1:0] conn_window_ff;
   logic [fwb_pkg::THR_W-1:0]  conn_thresh_ff;
   logic                       conn_policy_ff;
   logic [fwb_pkg::TIME_W-1:0] disk_window_ff;
   logic [fwb_pkg::THR_W-1:0]  disk_thresh_ff;
   logic                       disk_policy_ff;

   // sequencer
   logic [2:0] state_ff, state_in;
   logic                             cmd_ff, cmd_in;
   logic [fwb_pkg::DISK_W-1:0]       disk_ff, disk_in;
   logic [fwb_pkg::KIND_W-1:0]       kind_ff, kind_in;
   logic [fwb_pkg::TIME_W-1:0]       now_ff, now_in;
   logic [fwb_pkg::TIME_W-1:0]       limit_ff, limit_in;
   logic [fwb_pkg::SLOT_W-1:0]       head_ff, head_in;
   logic [fwb_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [fwb_pkg::CNT_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [fwb_pkg::CNT_W-1:0]        keep_ff, keep_in;
   logic                             pend_ff, pend_in;

   logic [fwb_pkg::OUTCOME_W-1:0]    res_outcome_ff, res_outcome_in;
   logic                             res_blocked_ff, res_blocked_in;
   logic                             res_reason_ff, res_reason_in;
   logic [fwb_pkg::CNT_W-1:0]        res_count_ff, res_count_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [fwb_pkg::OUTCOME_W-1:0]    rsp_outcome_ff, rsp_outcome_in;
   logic                             rsp_blocked_ff, rsp_blocked_in;
   logic                             rsp_reason_ff, rsp_reason_in;
   logic [fwb_pkg::CNT_W-1:0]        rsp_count_ff, rsp_count_in;

   logic blocked_ff   [fwb_pkg::NUM_DISKS];
   logic meta_vld_ff  [fwb_pkg::RING_DEPTH];

   // memory ports
   logic                          times_we;
   logic [fwb_pkg::TIMES_AW-1:0]  times_wa, times_ra;
   logic [fwb_pkg::TIME_W-1:0]    times_wd, times_rd;
   logic                          meta_we;
   fwb_pkg::ring_meta_type        meta_wd, meta_rd, meta_cur;
   logic [fwb_pkg::RING_W-1:0]    meta_ra;
   logic                          cause_we;
   logic [fwb_pkg::CAUSE_AW-1:0]  cause_ra;
   logic                          cause_rd;
   logic                          set_blocked;

   logic [fwb_pkg::RING_W-1:0]    ring;
   logic                          blk;
   logic                          out_of_range;
   logic [fwb_pkg::TIME_W-1:0]    sel_window;
   logic [fwb_pkg::THR_W-1:0]     sel_thresh;
   logic                          sel_policy;

   assign ring         = fwb_pkg::RING_W'({disk_ff, kind_ff[0]});
   assign blk          = blocked_ff[disk_ff];
   assign out_of_range = {1'b0, disk_ff} >= (fwb_pkg::DISK_W + 1)'(fwb_pkg::NUM_DISKS);
   assign meta_cur     = meta_vld_ff[ring] ? meta_rd : '0;
   assign sel_window   = kind_ff[0] ? disk_window_ff : conn_window_ff;
   assign sel_thresh   = kind_ff[0] ? disk_thresh_ff : conn_thresh_ff;
   assign sel_policy   = kind_ff[0] ? disk_policy_ff : conn_policy_ff;

   assign meta_ra  = (state_ff == ST_IDLE)
                     ? fwb_pkg::RING_W'({req_chan.disk_index, req_chan.error_kind[0]}) : ring;
   assign cause_ra = (state_ff == ST_IDLE)
                     ? fwb_pkg::CAUSE_AW'(req_chan.disk_index) : fwb_pkg::CAUSE_AW'(disk_ff);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.outcome         = rsp_outcome_ff;
   assign rsp_chan.blocked         = rsp_blocked_ff;
   assign rsp_chan.block_reason    = rsp_reason_ff;
   assign rsp_chan.window_failures = rsp_count_ff;

   fwb_ram #(.WIDTH(fwb_pkg::TIME_W), .DEPTH(fwb_pkg::TIMES_DEPTH)) u_times (
      .clock   (clock),
      .wr_en   (times_we),
      .wr_addr (times_wa),
      .wr_data (times_wd),
      .rd_addr (times_ra),
      .rd_data (times_rd)
   );

   fwb_ram #(.WIDTH($bits(fwb_pkg::ring_meta_type)), .DEPTH(fwb_pkg::RING_DEPTH)) u_meta (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (ring),
      .wr_data (meta_wd),
      .rd_addr (meta_ra),
      .rd_data (meta_rd)
   );

   fwb_ram #(.WIDTH(1), .DEPTH(fwb_pkg::NUM_DISKS)) u_cause (
      .clock   (clock),
      .wr_en   (cause_we),
      .wr_addr (fwb_pkg::CAUSE_AW'(disk_ff)),
      .wr_data (kind_ff[0]),
      .rd_addr (cause_ra),
      .rd_data (cause_rd)
   );

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      disk_in        = disk_ff;
      kind_in        = kind_ff;
      now_in         = now_ff;
      limit_in       = limit_ff;
      head_in        = head_ff;
      cnt_in         = cnt_ff;
      rd_idx_in      = rd_idx_ff;
      keep_in        = keep_ff;
      pend_in        = pend_ff;
      res_outcome_in = res_outcome_ff;
      res_blocked_in = res_blocked_ff;
      res_reason_in  = res_reason_ff;
      res_count_in   = res_count_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_chan.ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_blocked_in = rsp_blocked_ff;
      rsp_reason_in  = rsp_reason_ff;
      rsp_count_in   = rsp_count_ff;
      times_we       = 1'b0;
      times_wa       = '0;
      times_wd       = now_ff;
      times_ra       = '0;
      meta_we        = 1'b0;
      meta_wd        = '0;
      cause_we       = 1'b0;
      set_blocked    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = req_chan.cmd;
               disk_in  = req_chan.disk_index;
               kind_in  = req_chan.error_kind;
               now_in   = req_chan.now_ms;
               state_in = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            state_in       = ST_OUT;
            res_blocked_in = 1'b0;
            res_reason_in  = 1'b0;
            res_count_in   = '0;
            if (out_of_range) begin
               res_outcome_in = (cmd_ff == fwb_pkg::CMD_QUERY)
                                ? fwb_pkg::OUTCOME_QUERY : fwb_pkg::OUTCOME_UNKNOWN;
            end else if (cmd_ff == fwb_pkg::CMD_QUERY) begin
               res_outcome_in = fwb_pkg::OUTCOME_QUERY;
               res_blocked_in = blk;
               res_reason_in  = blk & cause_rd;
            end else if (kind_ff >= fwb_pkg::KIND_W'(fwb_pkg::NUM_KINDS)) begin
               res_outcome_in = fwb_pkg::OUTCOME_UNKNOWN;
               res_blocked_in = blk;
               res_reason_in  = blk & cause_rd;
            end else if (blk) begin
               res_outcome_in = fwb_pkg::OUTCOME_ALREADY;
               res_blocked_in = 1'b1;
               res_reason_in  = cause_rd;
               res_count_in   = meta_cur.count;
            end else if (!sel_policy) begin
               res_outcome_in = fwb_pkg::OUTCOME_NO_POLICY;
               res_count_in   = meta_cur.count;
            end else begin
               // append the new time, overwriting the oldest when full
               times_we = 1'b1;
               times_wd = now_ff;
               if (meta_cur.count >= fwb_pkg::CNT_W'(fwb_pkg::MAX_RECORDS)) begin
                  times_wa = fwb_pkg::times_addr(ring, meta_cur.head);
                  head_in  = fwb_pkg::wrap_slot((fwb_pkg::CNT_W + 1)'(meta_cur.head)
                                                + (fwb_pkg::CNT_W + 1)'(1));
                  cnt_in   = fwb_pkg::CNT_W'(fwb_pkg::MAX_RECORDS);
               end else begin
                  times_wa = fwb_pkg::times_addr(ring,
                                fwb_pkg::wrap_slot((fwb_pkg::CNT_W + 1)'(meta_cur.head)
                                                   + (fwb_pkg::CNT_W + 1)'(meta_cur.count)));
                  head_in  = meta_cur.head;
                  cnt_in   = meta_cur.count + fwb_pkg::CNT_W'(1);
               end
               if (sel_window == '0) begin
                  set_blocked    = 1'b1;
                  cause_we       = 1'b1;
                  meta_we        = 1'b1;
                  meta_wd        = '0;
                  res_outcome_in = fwb_pkg::OUTCOME_NEW_BLOCK;
                  res_blocked_in = 1'b1;
                  res_reason_in  = kind_ff[0];
               end else begin
                  limit_in  = (now_ff >= sel_window) ? now_ff - sel_window : '0;
                  rd_idx_in = '0;
                  keep_in   = '0;
                  pend_in   = 1'b0;
                  state_in  = ST_PRUNE;
               end
            end
         end

         ST_PRUNE: begin
            // one timestamp read per cycle, kept ones compacted toward the head
            if (rd_idx_ff < cnt_ff) begin
               times_ra  = fwb_pkg::times_addr(ring,
                              fwb_pkg::wrap_slot((fwb_pkg::CNT_W + 1)'(head_ff)
                                                 + (fwb_pkg::CNT_W + 1)'(rd_idx_ff)));
               rd_idx_in = rd_idx_ff + fwb_pkg::CNT_W'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && (times_rd >= limit_ff)) begin
               times_we = 1'b1;
               times_wd = times_rd;
               times_wa = fwb_pkg::times_addr(ring,
                             fwb_pkg::wrap_slot((fwb_pkg::CNT_W + 1)'(head_ff)
                                                + (fwb_pkg::CNT_W + 1)'(keep_ff)));
               keep_in  = keep_ff + fwb_pkg::CNT_W'(1);
            end
            if (!(rd_idx_ff < cnt_ff) && !pend_ff) begin
               state_in = ST_CLOSE;
            end
         end

         ST_CLOSE: begin
            state_in = ST_OUT;
            meta_we  = 1'b1;
            if (32'(keep_ff) < 32'(sel_thresh)) begin
               meta_wd.head   = head_ff;
               meta_wd.count  = keep_ff;
               res_outcome_in = fwb_pkg::OUTCOME_RECORDED;
               res_blocked_in = 1'b0;
               res_reason_in  = 1'b0;
               res_count_in   = keep_ff;
            end else begin
               meta_wd        = '0;
               set_blocked    = 1'b1;
               cause_we       = 1'b1;
               res_outcome_in = fwb_pkg::OUTCOME_NEW_BLOCK;
               res_blocked_in = 1'b1;
               res_reason_in  = kind_ff[0];
               res_count_in   = '0;
            end
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = res_outcome_ff;
               rsp_blocked_in = res_blocked_ff;
               rsp_reason_in  = res_reason_ff;
               rsp_count_in   = res_count_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      disk_ff        <= disk_in;
      kind_ff        <= kind_in;
      now_ff         <= now_in;
      limit_ff       <= limit_in;
      head_ff        <= head_in;
      cnt_ff         <= cnt_in;
      rd_idx_ff      <= rd_idx_in;
      keep_ff        <= keep_in;
      res_outcome_ff <= res_outcome_in;
      res_blocked_ff <= res_blocked_in;
      res_reason_ff  <= res_reason_in;
      res_count_ff   <= res_count_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_reason_ff  <= rsp_reason_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // blocked flags and ring bookkeeping valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fwb_pkg::NUM_DISKS; i++) begin
            blocked_ff[i] <= 1'b0;
         end
         for (int j = 0; j < fwb_pkg::RING_DEPTH; j++) begin
            meta_vld_ff[j] <= 1'b0;
         end
      end else begin
         if (set_blocked) begin
            blocked_ff[disk_ff] <= 1'b1;
         end
         if (meta_we) begin
            meta_vld_ff[ring] <= 1'b1;
         end
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         conn_window_ff <= '0;
         conn_thresh_ff <= fwb_pkg::THR_W'(1);
         conn_policy_ff <= 1'b1;
         disk_window_ff <= '0;
         disk_thresh_ff <= fwb_pkg::THR_W'(1);
         disk_policy_ff <= 1'b1;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            fwb_pkg::CSR_CONNECT_WINDOW:    conn_window_ff <= csr_chan.data[fwb_pkg::TIME_W-1:0];
            fwb_pkg::CSR_CONNECT_THRESHOLD: conn_thresh_ff <= csr_chan.data[fwb_pkg::THR_W-1:0];
            fwb_pkg::CSR_CONNECT_POLICY:    conn_policy_ff <= csr_chan.data[0];
            fwb_pkg::CSR_DISK_WINDOW:       disk_window_ff <= csr_chan.data[fwb_pkg::TIME_W-1:0];
            fwb_pkg::CSR_DISK_THRESHOLD:    disk_thresh_ff <= csr_chan.data[fwb_pkg::THR_W-1:0];
            fwb_pkg::CSR_DISK_POLICY:       disk_policy_ff <= csr_chan.data[0];
            default: begin
            end
         endcase
      end
   end

endmodule

### sim/tb_failure_window_blocklist.sv
`timescale 1ns / 1ps
// testbench for failure_window_blocklist: a directed table, then randomized phases, every
// response checked against the table's expectation or a local model of the per-disk failure windows
// depends on fwb_pkg, fwb_channels and the rtl of the block

module tb_failure_window_blocklist;
   import fwb_pkg::*;

   localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic                 blocked;
      logic                 block_reason;
      logic [CNT_W-1:0]     window_failures;
   } verdict_t;

   typedef struct packed {
      logic                  is_csr;
      logic                  has_exp;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_data;
      logic                  cmd;
      logic [DISK_W-1:0]     disk;
      logic [KIND_W-1:0]     kind;
      logic [TIME_W-1:0]     now;
      verdict_t              typed;
   } step_row_t;

   typedef struct {
      logic [TIME_W-1:0] cw;
      logic [THR_W-1:0]  ct;
      logic              cp;
      logic [TIME_W-1:0] dw;
      logic [THR_W-1:0]  dt;
      logic              dp;
      int                lo;
      int                hi;
      int                step;
      logic [TIME_W-1:0] jump;
      int                items;
      int                send_pct;
      int                stall_pct;
      int                hold;
   } phase_t;

   logic clock;
   logic reset;

   fwb_req_if req_if();
   fwb_rsp_if rsp_if();
   fwb_csr_if csr_if();

   failure_window_blocklist u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // model state
   logic              is_blocked [NUM_DISKS];
   logic              cause_io   [NUM_DISKS];
   logic [TIME_W-1:0] stamp      [RING_DEPTH][MAX_RECORDS];
   int                ring_start [RING_DEPTH];
   int                ring_fill  [RING_DEPTH];
   logic [TIME_W-1:0] win_ms     [NUM_KINDS];
   logic [THR_W-1:0]  thr        [NUM_KINDS];
   logic              pol_on     [NUM_KINDS];

   verdict_t          pending_verdicts [$];
   step_row_t         directed_plan [$];
   phase_t            phase_plan [$];
   logic [TIME_W-1:0] wall_ms;
   int                error_count;
   int                send_idle_pct;
   int                rsp_stall_pct;
   int                hold_left;

   function automatic verdict_t judge_request(input logic c, input logic [DISK_W-1:0] d,
                                              input logic [KIND_W-1:0] k,
                                              input logic [TIME_W-1:0] t);
      verdict_t          v;
      int                ring;
      int                n;
      logic [TIME_W-1:0] limit;
      logic [TIME_W-1:0] kept [MAX_RECORDS];
      v = '0;
      if (c == CMD_QUERY || k > KIND_IO) begin
         v.outcome = (c == CMD_QUERY) ? OUTCOME_QUERY : OUTCOME_UNKNOWN;
         v.blocked = is_blocked[d];
         v.block_reason = is_blocked[d] & cause_io[d];
         return v;
      end
      ring = int'(d) * NUM_KINDS + int'(k);
      if (is_blocked[d]) begin
         v.outcome = OUTCOME_ALREADY;
         v.blocked = 1'b1;
         v.block_reason = cause_io[d];
         v.window_failures = CNT_W'(ring_fill[ring]);
         return v;
      end
      if (!pol_on[k]) begin
         v.outcome = OUTCOME_NO_POLICY;
         v.window_failures = CNT_W'(ring_fill[ring]);
         return v;
      end
      // full ring drops its oldest entry
      if (ring_fill[ring] >= MAX_RECORDS) begin
         stamp[ring][ring_start[ring]] = t;
         ring_start[ring] = (ring_start[ring] + 1) % MAX_RECORDS;
      end else begin
         stamp[ring][(ring_start[ring] + ring_fill[ring]) % MAX_RECORDS] = t;
         ring_fill[ring] = ring_fill[ring] + 1;
      end
      if (win_ms[k] != '0) begin
         limit = (t >= win_ms[k]) ? t - win_ms[k] : '0;
         n = 0;
         for (int i = 0; i < ring_fill[ring]; i++) begin
            if (stamp[ring][(ring_start[ring] + i) % MAX_RECORDS] >= limit) begin
               kept[n] = stamp[ring][(ring_start[ring] + i) % MAX_RECORDS];
               n++;
            end
         end
         for (int i = 0; i < n; i++) begin
            stamp[ring][(ring_start[ring] + i) % MAX_RECORDS] = kept[i];
         end
         ring_fill[ring] = n;
         if (n < int'(thr[k])) begin
            v.outcome = OUTCOME_RECORDED;
            v.window_failures = CNT_W'(n);
            return v;
         end
      end
      is_blocked[d] = 1'b1;
      cause_io[d] = k[0];
      ring_start[ring] = 0;
      ring_fill[ring] = 0;
      v.outcome = OUTCOME_NEW_BLOCK;
      v.blocked = 1'b1;
      v.block_reason = k[0];
      return v;
   endfunction

   function automatic void note_register(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_CONNECT_WINDOW:    win_ms[KIND_CONNECT] = data;
         CSR_CONNECT_THRESHOLD: thr[KIND_CONNECT] = data[THR_W-1:0];
         CSR_CONNECT_POLICY:    pol_on[KIND_CONNECT] = data[0];
         CSR_DISK_WINDOW:       win_ms[KIND_IO] = data;
         CSR_DISK_THRESHOLD:    thr[KIND_IO] = data[THR_W-1:0];
         CSR_DISK_POLICY:       pol_on[KIND_IO] = data[0];
         default: ;
      endcase
   endfunction

   function automatic void advance_clock(input logic [TIME_W-1:0] delta);
      logic [TIME_W:0] sum;
      sum = {1'b0, wall_ms} + {1'b0, delta};
      wall_ms = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
   endfunction

   task automatic row_item(input logic c, input logic [DISK_W-1:0] d,
                           input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t);
      step_row_t r;
      r = '0;
      r.cmd = c;
      r.disk = d;
      r.kind = k;
      r.now = t;
      directed_plan.push_back(r);
   endtask

   task automatic row_check(input logic c, input logic [DISK_W-1:0] d,
                            input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t,
                            input logic [OUTCOME_W-1:0] o, input logic b, input logic rs,
                            input logic [CNT_W-1:0] w);
      step_row_t r;
      r = '0;
      r.has_exp = 1'b1;
      r.cmd = c;
      r.disk = d;
      r.kind = k;
      r.now = t;
      r.typed = '{o, b, rs, w};
      directed_plan.push_back(r);
   endtask

   task automatic row_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      step_row_t r;
      r = '0;
      r.is_csr = 1'b1;
      r.csr_idx = idx;
      r.csr_data = data;
      directed_plan.push_back(r);
   endtask

   task automatic add_phase(input logic [TIME_W-1:0] cw, input logic [THR_W-1:0] ct,
                            input logic cp, input logic [TIME_W-1:0] dw,
                            input logic [THR_W-1:0] dt, input logic dp, input int lo,
                            input int hi, input int step, input logic [TIME_W-1:0] jump,
                            input int items, input int send_pct, input int stall_pct,
                            input int hold);
      phase_t p;
      p = '{cw, ct, cp, dw, dt, dp, lo, hi, step, jump, items, send_pct, stall_pct, hold};
      phase_plan.push_back(p);
   endtask

   // offer one request, idle first at random; returns at the transfer edge
   task automatic offer_request(input logic c, input logic [DISK_W-1:0] d,
                                input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t,
                                input logic has_exp, input verdict_t typed);
      verdict_t got;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid      <= 1'b1;
      req_if.cmd        <= c;
      req_if.disk_index <= d;
      req_if.error_kind <= k;
      req_if.now_ms     <= t;
      do @(posedge clock); while (!req_if.ready);
      got = judge_request(c, d, k, t);
      pending_verdicts.push_back(has_exp ? typed : got);
   endtask

   task automatic drain_block();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      drain_block();
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      note_register(idx, data);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // response side: random stalls, plus a long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      verdict_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("response transfer with nothing expected: outcome %0d", rsp_if.outcome);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_if.outcome !== want.outcome) begin
               $error("outcome: expected %0d, got %0d", want.outcome, rsp_if.outcome);
               error_count++;
            end
            if (rsp_if.blocked !== want.blocked) begin
               $error("blocked: expected %0d, got %0d", want.blocked, rsp_if.blocked);
               error_count++;
            end
            if (rsp_if.block_reason !== want.block_reason) begin
               $error("block_reason: expected %0d, got %0d", want.block_reason,
                      rsp_if.block_reason);
               error_count++;
            end
            if (rsp_if.window_failures !== want.window_failures) begin
               $error("window_failures: expected %0d, got %0d", want.window_failures,
                      rsp_if.window_failures);
               error_count++;
            end
         end
      end
   end

   initial begin
      #(5_000_000);
      $display("tb_failure_window_blocklist: done, errors");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.cmd        = CMD_REPORT;
      req_if.disk_index = '0;
      req_if.error_kind = KIND_CONNECT;
      req_if.now_ms     = '0;
      csr_if.valid      = 1'b0;
      csr_if.index      = CSR_CONNECT_WINDOW;
      csr_if.data       = '0;
      error_count       = 0;
      send_idle_pct     = 0;
      rsp_stall_pct     = 0;
      hold_left         = 0;
      wall_ms           = '0;
      foreach (is_blocked[i]) begin
         is_blocked[i] = 1'b0;
         cause_io[i]   = 1'b0;
      end
      foreach (ring_fill[i]) begin
         ring_start[i] = 0;
         ring_fill[i]  = 0;
      end
      foreach (win_ms[i]) begin
         win_ms[i] = '0;
         thr[i]    = THR_W'(1);
         pol_on[i] = 1'b1;
      end

      // directed table, reset settings first
      row_check(CMD_QUERY,  6'd0,  KIND_CONNECT, 32'd0, OUTCOME_QUERY, 1'b0, 1'b0, 5'd0);
      row_check(CMD_REPORT, 6'd0,  KIND_OTHER, 32'd0, OUTCOME_UNKNOWN, 1'b0, 1'b0, 5'd0);
      row_check(CMD_REPORT, 6'd0,  KIND_SPARE, 32'd0, OUTCOME_UNKNOWN, 1'b0, 1'b0, 5'd0);
      row_check(CMD_REPORT, 6'd63, KIND_CONNECT, 32'd0, OUTCOME_NEW_BLOCK, 1'b1, 1'b0, 5'd0);
      row_check(CMD_QUERY,  6'd63, KIND_SPARE, '1, OUTCOME_QUERY, 1'b1, 1'b0, 5'd0);
      row_check(CMD_REPORT, 6'd63, KIND_IO, 32'd1, OUTCOME_ALREADY, 1'b1, 1'b0, 5'd0);
      row_check(CMD_REPORT, 6'd62, KIND_IO, 32'd2, OUTCOME_NEW_BLOCK, 1'b1, 1'b1, 5'd0);
      row_check(CMD_QUERY,  6'd62, KIND_CONNECT, 32'd0, OUTCOME_QUERY, 1'b1, 1'b1, 5'd0);
      row_check(CMD_REPORT, 6'd62, KIND_SPARE, 32'd2, OUTCOME_UNKNOWN, 1'b1, 1'b1, 5'd0);
      row_csr(CSR_CONNECT_POLICY, 32'd0);
      row_check(CMD_REPORT, 6'd1,  KIND_CONNECT, 32'd3, OUTCOME_NO_POLICY, 1'b0, 1'b0, 5'd0);
      row_csr(CSR_CONNECT_POLICY, 32'd1);
      row_csr(CSR_CONNECT_WINDOW, 32'hFFFF_FFFF);
      row_csr(CSR_CONNECT_THRESHOLD, 32'd0);
      // zero threshold with a saturated window limit
      row_check(CMD_REPORT, 6'd2,  KIND_CONNECT, 32'd4, OUTCOME_NEW_BLOCK, 1'b1, 1'b0, 5'd0);
      row_csr(CSR_CONNECT_WINDOW, 32'd10);
      row_csr(CSR_CONNECT_THRESHOLD, 32'd2);
      row_item(CMD_REPORT, 6'd3, KIND_CONNECT, 32'd20);
      row_item(CMD_REPORT, 6'd3, KIND_CONNECT, 32'd31);
      row_item(CMD_REPORT, 6'd3, KIND_CONNECT, 32'd41);
      row_item(CMD_REPORT, 6'd3, KIND_IO, 32'd41);
      row_csr(CSR_DISK_POLICY, 32'd0);
      row_check(CMD_REPORT, 6'd4,  KIND_IO, 32'd42, OUTCOME_NO_POLICY, 1'b0, 1'b0, 5'd0);
      row_csr(CSR_DISK_POLICY, 32'd1);
      row_csr(CSR_DISK_WINDOW, 32'd1000);
      row_csr(CSR_DISK_THRESHOLD, 32'd16);
      row_item(CMD_REPORT, 6'd4, KIND_IO, 32'd42);
      row_item(CMD_REPORT, 6'd4, KIND_IO, 32'd43);
      row_item(CMD_REPORT, 6'd4, KIND_IO, 32'd44);
      row_item(CMD_QUERY,  6'd4, KIND_IO, 32'd0);
      row_item(CMD_REPORT, 6'd4, KIND_CONNECT, 32'd50);
      row_csr(CSR_DISK_WINDOW, 32'd0);
      row_check(CMD_REPORT, 6'd4,  KIND_IO, 32'd50, OUTCOME_NEW_BLOCK, 1'b1, 1'b1, 5'd0);
      row_item(CMD_REPORT, 6'd4, KIND_CONNECT, 32'd51);

      // random phases: settings, disk range, time step, jump, items, idling, stalls, hold-off
      add_phase(32'd50, 5'd4, 1'b1, 32'd200, 5'd6, 1'b1, 5, 9, 3, 32'd0, 90, 0, 0, 0);
      add_phase(32'hFFFF_FFFF, 5'd31, 1'b1, 32'd1000, 5'd16, 1'b1, 10, 12, 2, 32'd0, 90,
                66, 0, 0);
      add_phase(32'd25, 5'd3, 1'b0, 32'd0, 5'd5, 1'b1, 13, 20, 4, 32'd0, 80, 0, 66, 0);
      add_phase(32'h7FFF_FFFF, 5'd16, 1'b1, 32'd40, 5'd0, 1'b1, 21, 26, 3, 32'h8000_0000,
                90, 15, 15, 0);
      add_phase(32'd20, 5'd5, 1'b1, 32'hFFFF_0000, 5'd31, 1'b1, 27, 32, 6, 32'h7000_0000,
                100, 0, 0, 400);
      add_phase(32'd20, 5'd5, 1'b0, 32'hFFFF_0000, 5'd31, 1'b0, 27, 32, 6, 32'd0, 80,
                66, 0, 0);
      add_phase(32'd100, 5'd8, 1'b1, 32'd60, 5'd3, 1'b1, 33, 40, 5, 32'h0FFF_FF00, 90,
                0, 66, 0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_csr) begin
            write_register(directed_plan[i].csr_idx, directed_plan[i].csr_data);
         end else begin
            offer_request(directed_plan[i].cmd, directed_plan[i].disk, directed_plan[i].kind,
                          directed_plan[i].now, directed_plan[i].has_exp,
                          directed_plan[i].typed);
         end
      end
      wall_ms = 32'd60;

      foreach (phase_plan[p]) begin
         write_register(CSR_CONNECT_WINDOW, phase_plan[p].cw);
         write_register(CSR_CONNECT_THRESHOLD, CSR_DATA_W'(phase_plan[p].ct));
         write_register(CSR_CONNECT_POLICY, CSR_DATA_W'(phase_plan[p].cp));
         write_register(CSR_DISK_WINDOW, phase_plan[p].dw);
         write_register(CSR_DISK_THRESHOLD, CSR_DATA_W'(phase_plan[p].dt));
         write_register(CSR_DISK_POLICY, CSR_DATA_W'(phase_plan[p].dp));
         send_idle_pct = phase_plan[p].send_pct;
         rsp_stall_pct = phase_plan[p].stall_pct;
         hold_left     = phase_plan[p].hold;
         advance_clock(phase_plan[p].jump);
         for (int n = 0; n < phase_plan[p].items; n++) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 78) begin
               advance_clock(TIME_W'($urandom_range(phase_plan[p].step)));
               offer_request(CMD_REPORT,
                             DISK_W'($urandom_range(phase_plan[p].hi, phase_plan[p].lo)),
                             $urandom_range(1) ? KIND_IO : KIND_CONNECT, wall_ms, 1'b0, '0);
            end else if (pick < 88) begin
               offer_request(CMD_QUERY, DISK_W'($urandom_range(NUM_DISKS - 1)),
                             KIND_W'($urandom_range(3)), $urandom(), 1'b0, '0);
            end else if (pick < 94) begin
               offer_request(CMD_REPORT, DISK_W'($urandom_range(NUM_DISKS - 1)),
                             $urandom_range(1) ? KIND_SPARE : KIND_OTHER, wall_ms, 1'b0, '0);
            end else begin
               advance_clock(TIME_W'($urandom_range(phase_plan[p].step)));
               offer_request(CMD_REPORT, DISK_W'($urandom_range(NUM_DISKS - 1)),
                             $urandom_range(1) ? KIND_IO : KIND_CONNECT, wall_ms, 1'b0, '0);
            end
         end
      end

      drain_block();
      repeat (30) @(posedge clock);
      if (error_count == 0 && pending_verdicts.size() == 0) begin
         $display("tb_failure_window_blocklist: done, clean");
      end else begin
         $display("tb_failure_window_blocklist: done, errors");
      end
      $finish;
   end

endmodule
